// ----- rtl/core/skt_pkg.sv -----
// Shared types and codes for the sorted key table.
package skt_pkg;

  localparam int KeyW   = 32;
  localparam int RecW   = 64;
  localparam int ModeW  = 3;
  localparam int StatW  = 2;
  localparam int CountW = 7;

  localparam logic [ModeW-1:0] MODE_INSERT = 3'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 3'd1;
  localparam logic [ModeW-1:0] MODE_LOOKUP = 3'd2;
  localparam logic [ModeW-1:0] MODE_MODIFY = 3'd3;
  localparam logic [ModeW-1:0] MODE_FIRST  = 3'd4;
  localparam logic [ModeW-1:0] MODE_SUCC   = 3'd5;
  localparam logic [ModeW-1:0] MODE_PRED   = 3'd6;

  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [StatW-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic load;  // capture request and register the compare vectors
    logic exec;  // apply update and produce the result word
  } cmd_t;

  typedef struct packed {
    logic [CountW-1:0] entry_count;
    logic [RecW-1:0]   record_out;
    logic [KeyW-1:0]   result_key;
    logic              key_valid;
    logic [StatW-1:0]  status;
  } result_t;

endpackage

// ----- rtl/core/sorted_key_table_core.sv -----
// Top level of the sorted key table: controller, cell datapath and output register.
//
//  Channel  Dir  Fields (lowest bit first)
//  s_*      in   mode[2:0], search_key[34:3], record_in[98:35], zero pad to 104
//  m_*      out  status[1:0], key_valid[2], result_key[34:3], record_out[98:35],
//                entry_count[105:99], zero pad to 112
//
// A request is taken in the accept cycle, which registers the compares of every
// cell against the key; the execute state then shifts or writes the cells and
// loads the output register, and waits while that register is busy.
// Reset empties the table at once; no clearing pass is needed. A new word is
// taken while a result still waits in the output register; execution holds only
// when that register is full and not being drained.
module sorted_key_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // mode, search_key, record_in
  input  logic [103:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, key_valid, result_key, record_out, entry_count
  output logic [111:0] m_tdata
);

  skt_pkg::cmd_t    cmd;
  skt_pkg::result_t result;
  skt_pkg::result_t out_q;
  logic             out_busy;

  // The output register is busy when it holds a word that is not leaving now.
  assign out_busy = m_tvalid && !m_tready;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .out_busy (out_busy),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  skt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (s_tdata[2:0]),
    .search_key (s_tdata[34:3]),
    .record_in  (s_tdata[98:35]),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_q <= result;
    end
  end

  assign m_tdata = {6'b0, out_q};

endmodule

// ----- rtl/core/skt_ctrl.sv -----
// Controller state machine for the sorted key table.
module skt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          out_busy,
  output logic          in_ready,
  output skt_pkg::cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EXEC;
      ST_EXEC: if (!out_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign cmd.load = in_ready && in_valid;
  assign cmd.exec = (state == ST_EXEC) && !out_busy;

  a_exec_after_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EXEC))
    else $error("load not followed by execute state");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.exec))
    else $error("load and execute in the same cycle");
  a_exec_returns: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> in_ready)
    else $error("controller did not return to idle");

endmodule

// ----- rtl/core/skt_datapath.sv -----
// Cell array of sorted keys and records with parallel compare and shift.
module skt_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skt_pkg::cmd_t                cmd,
  input  logic [skt_pkg::ModeW-1:0]    mode,
  input  logic [skt_pkg::KeyW-1:0]     search_key,
  input  logic [skt_pkg::RecW-1:0]     record_in,
  output skt_pkg::result_t             result
);

  localparam int N  = TABLE_DEPTH;
  localparam int CW = $clog2(N + 1);

  logic [skt_pkg::KeyW-1:0] keys [N];
  logic [skt_pkg::RecW-1:0] recs [N];
  logic [CW-1:0]            count;

  logic [skt_pkg::ModeW-1:0] mode_q;
  logic [skt_pkg::KeyW-1:0]  key_q;
  logic [skt_pkg::RecW-1:0]  rec_q;
  logic [N-1:0]              lt_q;
  logic [N-1:0]              eq_q;
  logic [N-1:0]              gt_q;

  logic [N-1:0] lt_c, eq_c, gt_c;
  logic [N-1:0] sel_succ, sel_pred;
  logic [skt_pkg::KeyW-1:0] succ_or [N+1];
  logic [skt_pkg::KeyW-1:0] pred_or [N+1];
  logic [skt_pkg::RecW-1:0] look_or [N+1];

  logic hit, full, do_ins, do_del, do_mod;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic valid;
      assign valid   = CW'(g) < count;
      assign lt_c[g] = valid && (keys[g] < search_key);
      assign eq_c[g] = valid && (keys[g] == search_key);
      assign gt_c[g] = valid && (keys[g] > search_key);

      if (g == 0) begin : g_first
        assign sel_succ[g] = gt_q[g];
      end else begin : g_rest
        assign sel_succ[g] = gt_q[g] && !gt_q[g-1];
      end
      if (g == N - 1) begin : g_last
        assign sel_pred[g] = lt_q[g];
      end else begin : g_inner
        assign sel_pred[g] = lt_q[g] && !lt_q[g+1];
      end

      assign succ_or[g+1] = succ_or[g] | (sel_succ[g] ? keys[g] : '0);
      assign pred_or[g+1] = pred_or[g] | (sel_pred[g] ? keys[g] : '0);
      assign look_or[g+1] = look_or[g] | (eq_q[g] ? recs[g] : '0);

      // Each cell decides locally from its own and its neighbor's compare bits.
      always_ff @(posedge clk) begin
        if (do_ins && !lt_q[g]) begin
          if (g == 0) begin
            keys[g] <= key_q;
            recs[g] <= rec_q;
          end else if (lt_q[(g == 0) ? 0 : g-1]) begin
            keys[g] <= key_q;
            recs[g] <= rec_q;
          end else begin
            keys[g] <= keys[(g == 0) ? 0 : g-1];
            recs[g] <= recs[(g == 0) ? 0 : g-1];
          end
        end else if (do_del && !lt_q[g] && (g != N - 1)) begin
          keys[g] <= keys[(g == N - 1) ? g : g+1];
          recs[g] <= recs[(g == N - 1) ? g : g+1];
        end else if (do_mod && eq_q[g]) begin
          recs[g] <= rec_q;
        end
      end
    end
  endgenerate

  assign succ_or[0] = '0;
  assign pred_or[0] = '0;
  assign look_or[0] = '0;

  assign hit    = |eq_q;
  assign full   = (count == CW'(N));
  assign do_ins = cmd.exec && (mode_q == skt_pkg::MODE_INSERT) && !hit && !full;
  assign do_del = cmd.exec && (mode_q == skt_pkg::MODE_DELETE) && hit;
  assign do_mod = cmd.exec && (mode_q == skt_pkg::MODE_MODIFY) && hit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      key_q  <= search_key;
      rec_q  <= record_in;
      lt_q   <= lt_c;
      eq_q   <= eq_c;
      gt_q   <= gt_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_ins) begin
      count <= count + 1'b1;
    end else if (do_del) begin
      count <= count - 1'b1;
    end
  end

  logic [CW-1:0] count_after;
  logic [CW+skt_pkg::CountW-1:0] count_ext;
  assign count_after = do_ins ? count + 1'b1 : (do_del ? count - 1'b1 : count);
  assign count_ext   = {{skt_pkg::CountW{1'b0}}, count_after};

  always_comb begin
    result             = '0;
    result.entry_count = count_ext[skt_pkg::CountW-1:0];
    case (mode_q)
      skt_pkg::MODE_INSERT:
        result.status = hit ? skt_pkg::ST_DUPLICATE :
                        (full ? skt_pkg::ST_FULL : skt_pkg::ST_OK);
      skt_pkg::MODE_DELETE, skt_pkg::MODE_MODIFY:
        result.status = hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
      skt_pkg::MODE_LOOKUP: begin
        result.status = hit ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
        result.key_valid  = hit;
        result.result_key = hit ? key_q : '0;
        result.record_out = look_or[N];
      end
      skt_pkg::MODE_FIRST: begin
        result.key_valid  = (count != '0);
        result.status     = (count != '0) ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
        result.result_key = (count != '0) ? keys[0] : '0;
      end
      skt_pkg::MODE_SUCC: begin
        result.key_valid  = |gt_q;
        result.status     = (|gt_q) ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
        result.result_key = succ_or[N];
      end
      skt_pkg::MODE_PRED: begin
        result.key_valid  = |lt_q;
        result.status     = (|lt_q) ? skt_pkg::ST_OK : skt_pkg::ST_NOT_FOUND;
        result.result_key = pred_or[N];
      end
      default: result.status = skt_pkg::ST_NOT_FOUND;
    endcase
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N))
    else $error("entry count above table depth");
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> $onehot0(eq_q))
    else $error("more than one cell matches the key");
  a_ordered_compare: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> ($onehot0(sel_succ) && $onehot0(sel_pred)))
    else $error("neighbor select not unique");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    do_ins |=> (count == $past(count) + 1'b1))
    else $error("insert did not grow the table");

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the sorted key table core.
`timescale 1ns / 100ps

module tb;

  localparam int Depth = 64;
  localparam int StallLimit = 20000;
  localparam logic [skt_pkg::ModeW-1:0] ModeUnused = 3'd7;

  typedef struct packed {
    logic [skt_pkg::CountW-1:0] count;
    logic [skt_pkg::RecW-1:0]   rec;
    logic [skt_pkg::KeyW-1:0]   key;
    logic                       kvalid;
    logic [skt_pkg::StatW-1:0]  status;
  } answer_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;

  // Predictor state: sorted keys and their records.
  logic [skt_pkg::KeyW-1:0] tbl_keys[Depth];
  logic [skt_pkg::RecW-1:0] tbl_recs[Depth];
  int                       tbl_fill;

  answer_t answer_q[$];
  int      mismatches;
  int      words_sent;
  int      words_checked;
  int      idle_cycles;
  bit      hold_off;
  bit      timed_out;

  sorted_key_table_core #(.TABLE_DEPTH(Depth)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Computes the answer of one request and updates the shadow table.
  function automatic answer_t predict_table(logic [skt_pkg::ModeW-1:0] mode,
                                            logic [skt_pkg::KeyW-1:0] key,
                                            logic [skt_pkg::RecW-1:0] rec);
    answer_t a;
    int pos;
    int j;
    bit hit;
    a = '0;
    pos = 0;
    while (pos < tbl_fill && tbl_keys[pos] < key) pos++;
    hit = (pos < tbl_fill) && (tbl_keys[pos] == key);
    case (mode)
      skt_pkg::MODE_INSERT: begin
        if (hit) a.status = skt_pkg::ST_DUPLICATE;
        else if (tbl_fill >= Depth) a.status = skt_pkg::ST_FULL;
        else begin
          for (j = tbl_fill; j > pos; j--) begin
            tbl_keys[j] = tbl_keys[j-1];
            tbl_recs[j] = tbl_recs[j-1];
          end
          tbl_keys[pos] = key;
          tbl_recs[pos] = rec;
          tbl_fill++;
        end
      end
      skt_pkg::MODE_DELETE: begin
        if (!hit) a.status = skt_pkg::ST_NOT_FOUND;
        else begin
          for (j = pos; j + 1 < tbl_fill; j++) begin
            tbl_keys[j] = tbl_keys[j+1];
            tbl_recs[j] = tbl_recs[j+1];
          end
          tbl_fill--;
        end
      end
      skt_pkg::MODE_LOOKUP: begin
        if (!hit) a.status = skt_pkg::ST_NOT_FOUND;
        else begin
          a.kvalid = 1'b1;
          a.key = key;
          a.rec = tbl_recs[pos];
        end
      end
      skt_pkg::MODE_MODIFY: begin
        if (!hit) a.status = skt_pkg::ST_NOT_FOUND;
        else tbl_recs[pos] = rec;
      end
      skt_pkg::MODE_FIRST: begin
        if (tbl_fill == 0) a.status = skt_pkg::ST_NOT_FOUND;
        else begin
          a.kvalid = 1'b1;
          a.key = tbl_keys[0];
        end
      end
      skt_pkg::MODE_SUCC: begin
        j = hit ? pos + 1 : pos;
        if (j < tbl_fill) begin
          a.kvalid = 1'b1;
          a.key = tbl_keys[j];
        end else a.status = skt_pkg::ST_NOT_FOUND;
      end
      skt_pkg::MODE_PRED: begin
        if (pos > 0) begin
          a.kvalid = 1'b1;
          a.key = tbl_keys[pos-1];
        end else a.status = skt_pkg::ST_NOT_FOUND;
      end
      default: a.status = skt_pkg::ST_NOT_FOUND;
    endcase
    a.count = tbl_fill[skt_pkg::CountW-1:0];
    return a;
  endfunction

  // Sender gap: mostly none or short, now and then long. The valid line
  // drops only when a gap follows, so the next word can go out right away.
  task automatic sender_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 55) n = 0;
    else if (n < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Offers one word and holds it until the block takes it.
  task automatic send_word(logic [skt_pkg::ModeW-1:0] mode, logic [skt_pkg::KeyW-1:0] key,
                           logic [skt_pkg::RecW-1:0] rec);
    s_tdata  <= {5'd0, rec, key, mode};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    answer_q.push_back(predict_table(mode, key, rec));
    words_sent++;
    @(negedge clk);
    sender_gap();
  endtask

  // Picks a key that is stored, if any.
  function automatic logic [skt_pkg::KeyW-1:0] stored_key();
    if (tbl_fill == 0) return $urandom;
    return tbl_keys[$urandom_range(0, tbl_fill - 1)];
  endfunction

  // Drains: waits until every answer is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (answer_q.size() != 0 && !timed_out) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Extremes of the keys and records, plus every mode on an empty table.
  task automatic test_directed();
    logic [skt_pkg::ModeW-1:0] m;
    for (int i = 0; i < 8; i++) begin
      m = i[skt_pkg::ModeW-1:0];
      send_word(m, 32'h0, 64'h0);
    end
    send_word(skt_pkg::MODE_INSERT, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_word(skt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 64'h1);
    send_word(skt_pkg::MODE_LOOKUP, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 64'h0);
    send_word(skt_pkg::MODE_SUCC, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_SUCC, 32'hFFFF_FFFF, 64'h0);
    send_word(skt_pkg::MODE_PRED, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_PRED, 32'hFFFF_FFFF, 64'h0);
    send_word(skt_pkg::MODE_PRED, 32'h8000_0000, 64'h0);
    send_word(skt_pkg::MODE_MODIFY, 32'h0, 64'hA5A5_5A5A_A5A5_5A5A);
    send_word(skt_pkg::MODE_MODIFY, 32'h1234, 64'h0);
    send_word(skt_pkg::MODE_LOOKUP, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_DELETE, 32'h1234, 64'h0);
    send_word(skt_pkg::MODE_DELETE, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_FIRST, 32'h0, 64'h0);
    send_word(ModeUnused, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  // Fills the table past its depth while the receiver holds off, so the
  // block backs up, then checks the full status and empties it again.
  task automatic test_full_table();
    drain();
    hold_off = 1'b1;
    for (int i = 0; i < Depth + 4; i++)
      send_word(skt_pkg::MODE_INSERT, $urandom, {$urandom, $urandom});
    send_word(skt_pkg::MODE_INSERT, stored_key(), 64'h0);
    send_word(skt_pkg::MODE_FIRST, 32'h0, 64'h0);
    send_word(skt_pkg::MODE_PRED, 32'hFFFF_FFFF, 64'h0);
    while (tbl_fill > 0) send_word(skt_pkg::MODE_DELETE, stored_key(), 64'h0);
  endtask

  // Random requests; keys from a narrow range a third of the time so that hits,
  // duplicates and neighbors are common.
  task automatic test_random(int count);
    logic [skt_pkg::ModeW-1:0] m;
    logic [skt_pkg::KeyW-1:0]  k;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) m = skt_pkg::MODE_INSERT;
      else if (r < 45) m = skt_pkg::MODE_DELETE;
      else if (r < 97) m = skt_pkg::ModeW'($urandom_range(2, 6));
      else m = ModeUnused;
      r = $urandom_range(0, 2);
      if (r == 0) k = $urandom;
      else if (r == 1) k = $urandom_range(0, 200);
      else k = stored_key();
      send_word(m, k, {$urandom, $urandom});
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 99);
      if (n < 60) m_tready <= 1'b1;
      else if (n < 95) m_tready <= 1'b0;
      else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    answer_t exp_a;
    answer_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[105:0];
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_tdata);
      end else begin
        exp_a = answer_q.pop_front();
        words_checked++;
        if (got !== exp_a || m_tdata[111:106] !== '0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected st=%0d kv=%0b key=%h rec=%h cnt=%0d,",
                     exp_a.status, exp_a.kvalid, exp_a.key, exp_a.rec, exp_a.count);
            $display("          got st=%0d kv=%0b key=%h rec=%h cnt=%0d",
                     got.status, got.kvalid, got.key, got.rec, got.count);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    words_sent = 0;
    hold_off = 1'b0;
    tbl_fill = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_table();
    test_random(1500);
    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d requests over all seven modes and the unused code, including a",
             words_sent);
    $display("full table under output back-pressure; %0d results checked.", words_checked);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sorted_key_table_core.f -----
rtl/core/skt_pkg.sv
rtl/core/skt_ctrl.sv
rtl/core/skt_datapath.sv
rtl/core/sorted_key_table_core.sv
bench/tb.sv
